// ===== hw/rtl/tpstd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpstd_pkg
// Shared types and constants for the two-pad slide and tap detector.
// ----------------------------------------------------------------------------
package tpstd_pkg;

    localparam int TIME_W    = 63;
    localparam int CHAN_W    = 4;
    localparam int REQ_W     = 2;
    localparam int GEST_W    = 2;
    localparam int WIN_W     = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 24;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ACTIVE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INACTIVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POLL     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED   = 2'd3;

    // gesture codes
    localparam logic [GEST_W-1:0] GEST_TAP        = 2'd0;
    localparam logic [GEST_W-1:0] GEST_ONE_TO_TWO = 2'd1;
    localparam logic [GEST_W-1:0] GEST_TWO_TO_ONE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLIDE_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_ONE_CHAN = 1'd1;

    localparam logic [WIN_W-1:0]  SLIDE_WINDOW_RST = 24'd300000;
    localparam logic [CHAN_W-1:0] PAD_ONE_CHAN_RST = 4'd6;

    // registered request handed to the gesture core
    typedef struct packed {
        logic              valid;
        logic [REQ_W-1:0]  req_type;
        logic [CHAN_W-1:0] channel;
        logic [TIME_W-1:0] now_us;
    } t_req;

    // results of one request: count 0..2, first gesture; a second one is always a tap
    typedef struct packed {
        logic [1:0]        cnt;
        logic [GEST_W-1:0] first;
    } t_gest_res;

endpackage : tpstd_pkg
`default_nettype wire

// ===== hw/rtl/tpstd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpstd_core
// Pad state, configuration registers and gesture decision for one request.
// ----------------------------------------------------------------------------
module tpstd_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [tpstd_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire  [tpstd_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  tpstd_pkg::t_req                   i_req,
    input  wire                               i_fire,
    output tpstd_pkg::t_gest_res              o_res
);
    import tpstd_pkg::*;

    logic [WIN_W-1:0]  r_window;
    logic [CHAN_W-1:0] r_pad_one_chan;
    logic              r_one_down, r_two_down;
    logic [TIME_W-1:0] r_one_time, r_two_time;
    logic              r_one_seen, r_two_seen;
    logic              r_slide_rep;

    logic              is_one;
    logic              down1, up1, down2, up2;
    logic              win1, win2;
    logic              s21, s12, tap1, tap2;
    logic              sr2;
    logic [TIME_W-1:0] gap1, gap2;

    assign is_one = (i_req.channel == r_pad_one_chan);

    // press time of zero means never pressed; time running backwards is inside
    assign gap1 = i_req.now_us - r_one_time;
    assign gap2 = i_req.now_us - r_two_time;
    assign win1 = (r_one_time != '0) &&
                  ((i_req.now_us < r_one_time) || (gap1 <= TIME_W'(r_window)));
    assign win2 = (r_two_time != '0) &&
                  ((i_req.now_us < r_two_time) || (gap2 <= TIME_W'(r_window)));

    assign down1 = r_one_down && !r_one_seen;
    assign up1   = !r_one_down && r_one_seen;
    assign down2 = r_two_down && !r_two_seen;
    assign up2   = !r_two_down && r_two_seen;

    assign s21  = down1 && r_two_down && !r_slide_rep && win2;
    assign s12  = down2 && r_one_down && !r_slide_rep && !s21 && win1;
    assign sr2  = r_slide_rep || s21 || s12;
    assign tap1 = up1 && !sr2 && !r_two_down;
    assign tap2 = up2 && !sr2 && !r_one_down;

    always_comb begin
        o_res.cnt   = 2'd0;
        o_res.first = GEST_TAP;
        if (i_req.valid && i_req.req_type == REQ_POLL) begin
            if (s21) begin
                o_res.cnt   = 2'd1;
                o_res.first = GEST_TWO_TO_ONE;
            end else if (s12) begin
                o_res.cnt   = 2'd1;
                o_res.first = GEST_ONE_TO_TWO;
            end else begin
                o_res.cnt = {1'b0, tap1} + {1'b0, tap2};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window       <= SLIDE_WINDOW_RST;
            r_pad_one_chan <= PAD_ONE_CHAN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SLIDE_WINDOW: r_window       <= i_cfg_data[WIN_W-1:0];
                CFG_PAD_ONE_CHAN: r_pad_one_chan <= i_cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_down  <= 1'b0;
            r_two_down  <= 1'b0;
            r_one_time  <= '0;
            r_two_time  <= '0;
            r_one_seen  <= 1'b0;
            r_two_seen  <= 1'b0;
            r_slide_rep <= 1'b0;
        end else if (i_fire) begin
            unique case (i_req.req_type)
                REQ_ACTIVE: begin
                    if (is_one) begin
                        r_one_down <= 1'b1;
                        r_one_time <= i_req.now_us;
                    end else begin
                        r_two_down <= 1'b1;
                        r_two_time <= i_req.now_us;
                    end
                end
                REQ_INACTIVE: begin
                    if (is_one) r_one_down <= 1'b0;
                    else        r_two_down <= 1'b0;
                end
                REQ_POLL: begin
                    // gesture ends once both pads are up
                    r_slide_rep <= sr2 && (r_one_down || r_two_down);
                    r_one_seen  <= r_one_down;
                    r_two_seen  <= r_two_down;
                end
                REQ_UNUSED: ;
                default: ;
            endcase
        end
    end

endmodule : tpstd_core
`default_nettype wire

// ===== hw/rtl/two_pad_slide_tap_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_pad_slide_tap_detector
// Slide and tap gesture detection from pad events and poll ticks.
// ----------------------------------------------------------------------------
// A request enters an input register, its gesture decision is made
// combinationally by the core, and its results go to a two-entry result
// register that drives the output stream. Pad events and polls with at
// most one result stream back to back while the output side is ready;
// after a poll that finds two taps, the next request that has a result
// waits while the first tap drains, and pad events pass meanwhile.
// Configuration writes take effect at the next clock and belong in idle
// periods.
module two_pad_slide_tap_detector (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [tpstd_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire  [tpstd_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [tpstd_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // channel[3:0], now_us[66:4]
    input  wire  [tpstd_pkg::REQ_W-1:0]        s_axis_tuser,  // req_type[1:0]
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [tpstd_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // gesture[1:0]
    output logic                               m_axis_tlast
);
    import tpstd_pkg::*;

    t_req              r_req;
    t_gest_res         res;
    logic              fire, pop, room;
    logic [1:0]        r_out_cnt;
    logic [GEST_W-1:0] r_out_g0, r_out_g1;
    logic              r_out_l0, r_out_l1;

    tpstd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_req      (r_req),
        .i_fire     (fire),
        .o_res      (res)
    );

    assign pop  = m_axis_tvalid && m_axis_tready;
    assign room = (r_out_cnt == 2'd0) || (r_out_cnt == 2'd1 && m_axis_tready);
    assign fire = r_req.valid && ((res.cnt == 2'd0) || room);
    assign s_axis_tready = !r_req.valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= '0;
        end else begin
            if (s_axis_tready) begin
                r_req.valid <= s_axis_tvalid;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_req.req_type <= s_axis_tuser;
                r_req.channel  <= s_axis_tdata[CHAN_W-1:0];
                r_req.now_us   <= s_axis_tdata[CHAN_W +: TIME_W];
            end
        end
    end

    // result register, entry 0 is on the bus
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= 2'd0;
        end else if (fire && res.cnt != 2'd0) begin
            r_out_cnt <= res.cnt;
        end else if (pop) begin
            r_out_cnt <= r_out_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res.cnt != 2'd0) begin
            r_out_g0 <= res.first;
            r_out_l0 <= (res.cnt == 2'd1);
            r_out_g1 <= GEST_TAP;
            r_out_l1 <= 1'b1;
        end else if (pop) begin
            r_out_g0 <= r_out_g1;
            r_out_l0 <= r_out_l1;
        end
    end

    assign m_axis_tvalid = (r_out_cnt != 2'd0);
    assign m_axis_tdata  = {{(M_TDATA_W-GEST_W){1'b0}}, r_out_g0};
    assign m_axis_tlast  = r_out_l0;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt != 2'd3)
        else $error("result register count out of range");

    a_pair_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_cnt == 2'd2) |-> !r_out_l0)
        else $error("first of two results marked last");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res.cnt != 2'd0) |=> m_axis_tvalid)
        else $error("results of a poll not presented");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res.cnt != 2'd0) |-> (r_out_cnt == 2'd0 || pop))
        else $error("results loaded over pending output");

endmodule : two_pad_slide_tap_detector
`default_nettype wire

// ===== dv/tb_two_pad_slide_tap_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_pad_slide_tap_detector
// Self-checking bench for the two-pad gesture detector. Pad events and polls
// go in on the input stream, and a behavioral gesture predictor works out the
// taps and slides each poll should give. Results on the output stream are
// checked in order against those predictions, over several register settings
// and with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module tb_two_pad_slide_tap_detector;
    import tpstd_pkg::*;

    localparam int                CYCLE_LIMIT   = 200000;
    localparam int                SETTLE_CYCLES = 8;
    localparam int                END_CYCLES    = 20;
    localparam logic [TIME_W-1:0] TIME_MAX      = '1;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [CHAN_W-1:0] chan;
        logic [TIME_W-1:0] stamp;
    } t_pad_req;

    typedef struct {
        logic [GEST_W-1:0] gesture;
        logic              is_last;
    } t_gesture_exp;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // channel[3:0], now_us[66:4]
    logic [REQ_W-1:0]      s_axis_tuser  = '0;  // req_type[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // gesture[1:0]
    logic                  m_axis_tlast;

    two_pad_slide_tap_detector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor copy of the detector state and registers
    logic [WIN_W-1:0]  win_cfg     = SLIDE_WINDOW_RST;
    logic [CHAN_W-1:0] pad_one_cfg = PAD_ONE_CHAN_RST;
    logic              p1_down     = 1'b0;
    logic              p2_down     = 1'b0;
    logic [TIME_W-1:0] p1_press    = '0;
    logic [TIME_W-1:0] p2_press    = '0;
    logic              p1_seen     = 1'b0;
    logic              p2_seen     = 1'b0;
    logic              slide_done  = 1'b0;

    t_gesture_exp      gesture_q[$];
    t_gesture_exp      got_exp;
    int                err_cnt     = 0;
    int                sent_cnt    = 0;
    int                cycle_cnt   = 0;
    bit                calm        = 1'b0;
    logic [TIME_W-1:0] now_t       = '0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL two_pad_slide_tap_detector");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 11);
    end

    task automatic report_mismatch(input string what);
        if (err_cnt < 100)
            $display("[%0t] mismatch: %s", $time, what);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (gesture_q.size() == 0) begin
                report_mismatch($sformatf("gesture %0d with none pending",
                                          m_axis_tdata[GEST_W-1:0]));
            end else begin
                got_exp = gesture_q.pop_front();
                if (m_axis_tdata[GEST_W-1:0] !== got_exp.gesture)
                    report_mismatch($sformatf("gesture %0d, wanted %0d",
                                              m_axis_tdata[GEST_W-1:0], got_exp.gesture));
                if (m_axis_tlast !== got_exp.is_last)
                    report_mismatch($sformatf("tlast %0b, wanted %0b",
                                              m_axis_tlast, got_exp.is_last));
            end
        end
    end

    function automatic bit in_window(input logic [TIME_W-1:0] start,
                                     input logic [TIME_W-1:0] stamp);
        if (start == '0)
            return 1'b0;  // zero press time means never pressed
        if (stamp < start)
            return 1'b1;  // negative gap lies inside the window
        return (stamp - start) <= TIME_W'(win_cfg);
    endfunction

    task automatic predict_gestures(input t_pad_req r);
        logic              one, t1, t2, d1, d2, u1, u2;
        logic [GEST_W-1:0] found [2];
        int                n;
        t_gesture_exp      e;
        n   = 0;
        one = (r.chan == pad_one_cfg);
        case (r.kind)
            REQ_ACTIVE: begin
                if (one) begin
                    p1_press = r.stamp;
                    p1_down  = 1'b1;
                end else begin
                    p2_press = r.stamp;
                    p2_down  = 1'b1;
                end
            end
            REQ_INACTIVE: begin
                if (one)
                    p1_down = 1'b0;
                else
                    p2_down = 1'b0;
            end
            REQ_POLL: begin
                t1 = p1_down;
                t2 = p2_down;
                d1 = t1 && !p1_seen;
                u1 = !t1 && p1_seen;
                d2 = t2 && !p2_seen;
                u2 = !t2 && p2_seen;
                if (d1 && t2 && !slide_done && in_window(p2_press, r.stamp)) begin
                    found[n] = GEST_TWO_TO_ONE;
                    n++;
                    slide_done = 1'b1;
                end
                if (d2 && t1 && !slide_done && in_window(p1_press, r.stamp)) begin
                    found[n] = GEST_ONE_TO_TWO;
                    n++;
                    slide_done = 1'b1;
                end
                if (u1 && !slide_done && !t2) begin
                    found[n] = GEST_TAP;
                    n++;
                end
                if (u2 && !slide_done && !t1) begin
                    found[n] = GEST_TAP;
                    n++;
                end
                if (!t1 && !t2)
                    slide_done = 1'b0;
                p1_seen = t1;
                p2_seen = t2;
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++) begin
            e.gesture = found[k];
            e.is_last = (k == n - 1);
            gesture_q.push_back(e);
        end
    endtask

    task automatic send_req(input logic [REQ_W-1:0]  kind,
                            input logic [CHAN_W-1:0] chan,
                            input logic [TIME_W-1:0] stamp);
        t_pad_req r;
        r.kind  = kind;
        r.chan  = chan;
        r.stamp = stamp;
        if (!calm && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - TIME_W - CHAN_W){1'b0}}, stamp, chan};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_gestures(r);
        if (kind != REQ_UNUSED)
            sent_cnt++;
    endtask

    // drop the request line and wait for the block to go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (gesture_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_SLIDE_WINDOW)
            win_cfg = val[WIN_W-1:0];
        else
            pad_one_cfg = val[CHAN_W-1:0];
    endtask

    function automatic logic [TIME_W-1:0] rand_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] new_base();
        case ($urandom_range(3))
            0:       return '0;
            1:       return TIME_W'($urandom);
            2:       return TIME_MAX - TIME_W'($urandom);
            default: return rand_stamp();
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] pad_two_chan();
        logic [CHAN_W-1:0] c;
        c = CHAN_W'($urandom_range(15));
        if (c == pad_one_cfg)
            c = c + 1'b1;
        return c;
    endfunction

    // many gaps cluster around the slide window edge; now and then time steps back
    task automatic step_time();
        logic [63:0] gap, sum;
        if ($urandom_range(19) == 0 && now_t > 100) begin
            now_t = now_t - TIME_W'($urandom_range(1, 100));
        end else begin
            case ($urandom_range(4))
                0: gap = '0;
                1: gap = 64'($urandom_range(1000));
                2: begin
                    gap = 64'(win_cfg) + 64'($urandom_range(2));
                    if (gap != 0)
                        gap = gap - 64'd1;
                end
                3: gap = 64'($urandom_range(2 * int'(win_cfg) + 2));
                default: gap = 64'($urandom);
            endcase
            sum = {1'b0, now_t} + gap;
            now_t = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
        end
    endtask

    task automatic poll();
        send_req(REQ_POLL, CHAN_W'($urandom_range(15)), now_t);
    endtask

    // one press-release sequence over one or both pads
    task automatic play_gesture();
        logic [CHAN_W-1:0] ch_a, ch_b, tmp;
        bit                one_first, second_press;
        if ($urandom_range(19) == 0)
            now_t = new_base();
        one_first = $urandom_range(1);
        ch_a = one_first ? pad_one_cfg : pad_two_chan();
        ch_b = one_first ? pad_two_chan() : pad_one_cfg;
        send_req(REQ_ACTIVE, ch_a, now_t);
        if ($urandom_range(9) < 8)
            poll();
        second_press = ($urandom_range(9) < 7);
        if (second_press) begin
            step_time();
            send_req(REQ_ACTIVE, ch_b, now_t);
            if ($urandom_range(9) < 8)
                poll();
        end
        step_time();
        if (second_press && $urandom_range(1)) begin
            tmp  = ch_a;
            ch_a = ch_b;
            ch_b = tmp;
        end
        send_req(REQ_INACTIVE, ch_a, now_t);
        if ($urandom_range(9) < 6) begin
            step_time();
            poll();
        end
        if (second_press)
            send_req(REQ_INACTIVE, ch_b, now_t);
        poll();
    endtask

    task automatic run_phase(input int n_items, input logic [WIN_W-1:0] win,
                             input logic [CHAN_W-1:0] chan, input bit quiet);
        int target;
        settle();
        write_cfg(CFG_SLIDE_WINDOW, CFG_DAT_W'(win));
        write_cfg(CFG_PAD_ONE_CHAN, CFG_DAT_W'(chan));
        calm   = quiet;
        now_t  = new_base();
        target = sent_cnt + n_items;
        while (sent_cnt < target) begin
            if ($urandom_range(9) < 8) begin
                play_gesture();
            end else begin
                // stray events, unused request kinds and odd time stamps
                send_req(REQ_W'($urandom_range(3)), CHAN_W'($urandom_range(15)),
                         ($urandom_range(9) == 0) ? rand_stamp() : now_t);
            end
        end
        calm = 1'b0;
    endtask

    // reset register values: pad one on channel 6, 300 ms window
    task automatic test_directed();
        send_req(REQ_UNUSED,   4'd6,  TIME_MAX);
        // press at time zero never starts a slide; both released gives two taps
        send_req(REQ_ACTIVE,   4'd6,  63'd0);
        send_req(REQ_POLL,     4'd0,  63'd0);
        send_req(REQ_ACTIVE,   4'd9,  63'd5);
        send_req(REQ_POLL,     4'd0,  63'd5);
        send_req(REQ_INACTIVE, 4'd6,  63'd6);
        send_req(REQ_INACTIVE, 4'd9,  63'd6);
        send_req(REQ_POLL,     4'd15, 63'd7);
        // time running backwards still counts as inside the window
        send_req(REQ_ACTIVE,   4'd15, 63'd1000);
        send_req(REQ_POLL,     4'd0,  63'd1000);
        send_req(REQ_ACTIVE,   4'd6,  63'd500);
        send_req(REQ_POLL,     4'd0,  63'd400);
        send_req(REQ_INACTIVE, 4'd6,  63'd1200);
        send_req(REQ_INACTIVE, 4'd15, 63'd1200);
        send_req(REQ_POLL,     4'd0,  63'd1200);
        // gap exactly on the window edge, no tap after a slide
        send_req(REQ_ACTIVE,   4'd6,  63'd2000);
        send_req(REQ_POLL,     4'd0,  63'd2000);
        send_req(REQ_ACTIVE,   4'd0,  63'd302000);
        send_req(REQ_POLL,     4'd0,  63'd302000);
        send_req(REQ_INACTIVE, 4'd0,  63'd302001);
        send_req(REQ_POLL,     4'd0,  63'd302002);
        send_req(REQ_INACTIVE, 4'd6,  63'd302003);
        send_req(REQ_POLL,     4'd0,  63'd302004);
        // single tap at the top of the time range
        send_req(REQ_ACTIVE,   4'd6,  TIME_MAX);
        send_req(REQ_POLL,     4'd15, TIME_MAX);
        send_req(REQ_INACTIVE, 4'd6,  TIME_MAX);
        send_req(REQ_POLL,     4'd15, TIME_MAX);
    endtask

    task automatic test_window_extremes();
        run_phase(300, '0, PAD_ONE_CHAN_RST, 1'b0);
        run_phase(300, '1, PAD_ONE_CHAN_RST, 1'b0);
    endtask

    task automatic test_channel_map();
        run_phase(300, WIN_W'(1000), 4'd0, 1'b0);
        run_phase(300, WIN_W'(1), 4'd15, 1'b0);
    endtask

    task automatic test_back_to_back();
        run_phase(300, SLIDE_WINDOW_RST, PAD_ONE_CHAN_RST, 1'b1);
    endtask

    task automatic test_random_config();
        repeat (2) begin
            run_phase(210,
                      $urandom_range(1) ? WIN_W'($urandom_range(2000))
                                        : WIN_W'($urandom_range(16777215)),
                      CHAN_W'($urandom_range(15)), 1'b0);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_window_extremes();
        test_channel_map();
        test_back_to_back();
        test_random_config();
        settle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("PASS two_pad_slide_tap_detector");
        else
            $display("FAIL two_pad_slide_tap_detector");
        $finish;
    end

endmodule
